// ----- design/fpa_pkg.sv -----
// Shared types and constants for the Q24.8 fixed-point ALU.
// No dependencies.
`default_nettype none
package fpa_pkg;
    localparam int FRAC_BITS = 8;
    localparam int DW = 32;
    localparam int NUM_W = DW + FRAC_BITS;     // divide numerator width
    localparam int QW = NUM_W + 1;              // quotient width, room for rounding bit

    localparam logic [3:0] OP_ADD = 4'd0;
    localparam logic [3:0] OP_SUB = 4'd1;
    localparam logic [3:0] OP_MUL = 4'd2;
    localparam logic [3:0] OP_DIV = 4'd3;
    localparam logic [3:0] OP_MIN = 4'd4;
    localparam logic [3:0] OP_MAX = 4'd5;
    localparam logic [3:0] OP_INC = 4'd6;
    localparam logic [3:0] OP_DEC = 4'd7;
    localparam logic [3:0] OP_CMP = 4'd8;
    localparam logic [3:0] OP_I2F = 4'd9;
    localparam logic [3:0] OP_F2I = 4'd10;

    typedef struct packed {
        logic [3:0]        func;
        logic              neg;      // sign of mul/div result
        logic              dz;
        logic              lt;
        logic              eq;
        logic              gt;
        logic signed [DW-1:0] simple;  // result of non mul/div ops
        logic              simple_ovf;
    } ctl_t;

    // saturate a wide signed value to 32 bits
    function automatic logic [DW:0] sat_wide(input logic signed [DW+1:0] v);
        logic [DW:0] r;
        if (v > $signed({{2{1'b0}}, {(DW-1){1'b1}}}))
            r = {1'b1, 1'b0, {(DW-1){1'b1}}};
        else if (v < -$signed({{2{1'b0}}, 1'b1, {(DW-1){1'b0}}}))
            r = {1'b1, 1'b1, {(DW-1){1'b0}}};
        else
            r = {1'b0, v[DW-1:0]};
        return r;
    endfunction
endpackage
`default_nettype wire

// ----- design/fixed_point_q24_8_alu.sv -----
// Signed Q24.8 fixed-point ALU, fully pipelined.
// All operations pass through the same pipeline, whose depth is set by the
// one-bit-per-stage divider.
// Throughput: one transfer per cycle; a stall freezes the whole pipeline.
// Reset (rst_n, asynchronous, active low) clears the valid bits only.
`default_nettype none
module fixed_point_q24_8_alu (
    input  wire         clk,
    input  wire         rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [71:0]  s_axis_tdata,  // func[3:0], operand_a[35:4], operand_b[67:36], zero pad
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [39:0] m_axis_tdata   // result[31:0], less, equal, greater, overflow, div_by_zero, pad
);
    localparam int DW = fpa_pkg::DW;
    localparam int FB = fpa_pkg::FRAC_BITS;
    localparam int QW = fpa_pkg::QW;
    localparam int LAT = QW + 2;

    logic en;
    logic [LAT-1:0] vld_reg;
    assign en = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = en;
    assign m_axis_tvalid = vld_reg[LAT-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (en)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end

    // ---- stage 0: decode, simple ops, magnitudes
    logic [3:0] func;
    logic signed [DW-1:0] a, b;
    assign func = s_axis_tdata[3:0];
    assign a = s_axis_tdata[35:4];
    assign b = s_axis_tdata[67:36];

    fpa_pkg::ctl_t c0;
    logic [DW-1:0] ma, mb;
    logic [DW:0] s_add;
    always_comb
    begin
        ma = a[DW-1] ? DW'(-a) : a;
        mb = b[DW-1] ? DW'(-b) : b;
        c0 = '0;
        c0.func = func;
        c0.lt = a < b;
        c0.eq = a == b;
        c0.gt = a > b;
        c0.neg = a[DW-1] ^ b[DW-1];
        c0.dz = (func == fpa_pkg::OP_DIV) && (b == 0);
        s_add = '0;
        case (func)
            fpa_pkg::OP_ADD: s_add = fpa_pkg::sat_wide((DW+2)'(a) + (DW+2)'(b));
            fpa_pkg::OP_SUB: s_add = fpa_pkg::sat_wide((DW+2)'(a) - (DW+2)'(b));
            fpa_pkg::OP_INC: s_add = fpa_pkg::sat_wide((DW+2)'(a) + 1);
            fpa_pkg::OP_DEC: s_add = fpa_pkg::sat_wide((DW+2)'(a) - 1);
            fpa_pkg::OP_MIN: s_add = {1'b0, (a < b) ? a : b};
            fpa_pkg::OP_MAX: s_add = {1'b0, (a > b) ? a : b};
            fpa_pkg::OP_I2F:
            begin
                // fits only when the top FB+1 bits are all sign copies
                if (a[DW-1:DW-1-FB] == '0 || a[DW-1:DW-1-FB] == {(FB+1){1'b1}})
                    s_add = {1'b0, a[DW-1-FB:0], {FB{1'b0}}};
                else if (a[DW-1])
                    s_add = {1'b1, 1'b1, {(DW-1){1'b0}}};
                else
                    s_add = {1'b1, 1'b0, {(DW-1){1'b1}}};
            end
            fpa_pkg::OP_F2I: s_add = {1'b0, a >>> FB};
            default:         s_add = '0;
        endcase
        c0.simple = s_add[DW-1:0];
        c0.simple_ovf = s_add[DW];
    end

    // stage 1 registers: control, magnitudes
    fpa_pkg::ctl_t c1_reg;
    logic [DW-1:0] ma_reg, mb_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c1_reg <= c0;
            ma_reg <= ma;
            mb_reg <= mb;
        end
    end

    // stage 2: product register; divider starts from stage 1 values
    logic [2*DW-1:0] prod_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            prod_reg <= ma_reg * mb_reg;
    end

    // numerator 2*|a|<<FB + |b|, divisor 2*|b|, giving the rounded quotient
    logic [QW-1:0] dnum;
    logic [QW-1:0] quo;
    assign dnum = {ma_reg, {FB{1'b0}}, 1'b0} + QW'(mb_reg);
    fpa_div u_div (
        .clk  (clk),
        .en   (en),
        .num  (dnum),
        .den  ({mb_reg[DW-2:0], 1'b0}),
        .quo  (quo)
    );
    // den doubled: |b| up to 2^31 makes 2|b| = 2^32, handled by top bit below
    logic big_b;
    assign big_b = mb_reg[DW-1];

    // delay line for control, product rounding and big-divisor case;
    // its last entry lines up with the divider's last stage
    localparam int DL = QW - 1;
    fpa_pkg::ctl_t c_dl_reg [DL];
    logic [DW:0]   pm_dl_reg [DL];   // rounded product magnitude, sticky-saturated
    logic          bb_dl_reg [DL];
    logic [FB:0]   bq_dl_reg [DL];   // quotient when |b| = 2^31
    logic [2*DW-1:0] pr;
    logic [2*DW-FB-1:0] pm;
    always_comb
    begin
        pr = prod_reg + (2*DW)'(1 << (FB-1));
        pm = pr[2*DW-1:FB];
    end
    // stage-1 quotient for |b| = 2^31: round(|a|*2^FB / 2^31), at most 2^FB
    logic [FB:0] bq;
    assign bq = (FB+1)'((({1'b0, ma_reg} << FB) + ((DW+FB+1)'(1) << (DW-2))) >> (DW-1));

    fpa_pkg::ctl_t c2_reg;
    logic bb2_reg;
    logic [FB:0] bq2_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c2_reg  <= c1_reg;
            bb2_reg <= big_b;
            bq2_reg <= bq;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            c_dl_reg[0]  <= c2_reg;
            pm_dl_reg[0] <= (pm[2*DW-FB-1:DW] != '0) ? {1'b1, {DW{1'b0}}} : {1'b0, pm[DW-1:0]};
            bb_dl_reg[0] <= bb2_reg;
            bq_dl_reg[0] <= bq2_reg;
            for (int i = 1; i < DL; i++)
            begin
                c_dl_reg[i]  <= c_dl_reg[i-1];
                pm_dl_reg[i] <= pm_dl_reg[i-1];
                bb_dl_reg[i] <= bb_dl_reg[i-1];
                bq_dl_reg[i] <= bq_dl_reg[i-1];
            end
        end
    end

    // final stage: select, sign and saturate
    fpa_pkg::ctl_t cf;
    logic [QW-1:0] mag;
    logic [DW-1:0] res;
    logic ovf;
    always_comb
    begin
        cf = c_dl_reg[DL-1];
        mag = '0;
        res = cf.simple;
        ovf = cf.simple_ovf;
        if (cf.func == fpa_pkg::OP_MUL || (cf.func == fpa_pkg::OP_DIV && !cf.dz))
        begin
            if (cf.func == fpa_pkg::OP_MUL)
                mag = QW'(pm_dl_reg[DL-1]);
            else if (bb_dl_reg[DL-1])
                mag = QW'(bq_dl_reg[DL-1]);
            else
                mag = quo;
            if (cf.neg)
            begin
                if (mag > QW'(33'h1_0000_0000 >> 1))
                begin
                    res = {1'b1, {(DW-1){1'b0}}};
                    ovf = 1'b1;
                end
                else
                begin
                    res = DW'(-mag);
                    ovf = 1'b0;
                end
            end
            else if (mag > QW'({(DW-1){1'b1}}))
            begin
                res = {1'b0, {(DW-1){1'b1}}};
                ovf = 1'b1;
            end
            else
            begin
                res = mag[DW-1:0];
                ovf = 1'b0;
            end
        end
        else if (cf.func == fpa_pkg::OP_DIV)
        begin
            res = '0;
            ovf = 1'b0;
        end
    end

    logic [39:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (en)
            out_reg <= {3'b000, cf.dz, ovf, cf.gt, cf.eq, cf.lt, res};
    end
    assign m_axis_tdata = out_reg;
endmodule
`default_nettype wire

// ----- design/fpa_div.sv -----
// Pipelined restoring divider of unsigned magnitudes, one quotient bit per stage.
// Depends on fpa_pkg.
`default_nettype none
module fpa_div (
    input  wire                          clk,
    input  wire                          en,
    input  wire [fpa_pkg::QW-1:0]        num,
    input  wire [fpa_pkg::DW-1:0]        den,
    output logic [fpa_pkg::QW-1:0]       quo
);
    localparam int N = fpa_pkg::QW;
    localparam int RW = fpa_pkg::DW + 1;

    logic [N-1:0]  q_reg [N];
    logic [N-1:0]  n_reg [N];
    logic [RW-1:0] r_reg [N];
    logic [fpa_pkg::DW-1:0] d_reg [N];

    // stage s handles numerator bit N-1-s
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            for (int s = 0; s < N; s++)
            begin
                logic [RW:0] t;
                logic [RW-1:0] rin;
                logic [N-1:0] nin, qin;
                logic [fpa_pkg::DW-1:0] din;
                rin = (s == 0) ? '0 : r_reg[(s == 0) ? 0 : s-1];
                nin = (s == 0) ? num : n_reg[(s == 0) ? 0 : s-1];
                qin = (s == 0) ? '0 : q_reg[(s == 0) ? 0 : s-1];
                din = (s == 0) ? den : d_reg[(s == 0) ? 0 : s-1];
                t = {rin, nin[N-1]};
                if (t >= {2'b00, din})
                begin
                    r_reg[s] <= RW'(t - {2'b00, din});
                    q_reg[s] <= {qin[N-2:0], 1'b1};
                end
                else
                begin
                    r_reg[s] <= t[RW-1:0];
                    q_reg[s] <= {qin[N-2:0], 1'b0};
                end
                n_reg[s] <= {nin[N-2:0], 1'b0};
                d_reg[s] <= din;
            end
        end
    end

    assign quo = q_reg[N-1];
endmodule
`default_nettype wire
